[hw/rtl/elastic_collision_velocity_top_defines.svh]
// ---------------------------------------------------------------------------
// Elastic collision velocity - assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ---------------------------------------------------------------------------
`ifndef ELASTIC_COLLISION_VELOCITY_TOP_DEFINES_SVH
`define ELASTIC_COLLISION_VELOCITY_TOP_DEFINES_SVH

// same-cycle implication
`define ECV_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ecv: same-cycle check failed");

// next-cycle implication
`define ECV_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ecv: next-cycle check failed");

`endif

[hw/rtl/ecv_pkg.sv]
// ---------------------------------------------------------------------------
// Elastic collision velocity - package
// Widths, pipeline depths and shared types.
// ---------------------------------------------------------------------------
package ecv_pkg;

    localparam int AXES       = 3;
    localparam int LANES      = 2 * AXES;    // A x,y,z then B x,y,z
    localparam int QW         = 36;          // quotient bits, one per divider stage
    localparam int DENW       = 97;          // (mass_a + mass_b) * |r|^2
    localparam int DW         = DENW + 1;    // divisor 2*den
    localparam int NW         = 132;         // dividend 2*num + den
    localparam int PRE_STAGES = 8;
    localparam int NUM_STAGES = PRE_STAGES + QW + 1;

    typedef logic [NW-1:0] num_t;
    typedef logic [DW-1:0] dsr_t;
    typedef logic [QW-1:0] quot_t;

    typedef struct packed {
        logic [AXES-1:0][31:0] va;
        logic [AXES-1:0][31:0] vb;
        logic [AXES-1:0]       rneg;
        logic                  pneg;
        logic                  deg;
    } side_t;

endpackage

[hw/rtl/ecv_if.sv]
// ---------------------------------------------------------------------------
// Elastic collision velocity - channel interfaces
// Request channel (two bodies) and result channel (new velocities).
// ---------------------------------------------------------------------------
interface ecv_req_if;
    logic              valid;
    logic              ready;
    logic [31:0]       mass_a;
    logic [31:0]       mass_b;
    logic signed [31:0] sep_x;
    logic signed [31:0] sep_y;
    logic signed [31:0] sep_z;
    logic signed [31:0] vel_a_x;
    logic signed [31:0] vel_a_y;
    logic signed [31:0] vel_a_z;
    logic signed [31:0] vel_b_x;
    logic signed [31:0] vel_b_y;
    logic signed [31:0] vel_b_z;

    modport source (
        output valid, mass_a, mass_b, sep_x, sep_y, sep_z,
               vel_a_x, vel_a_y, vel_a_z, vel_b_x, vel_b_y, vel_b_z,
        input  ready
    );
    modport sink (
        input  valid, mass_a, mass_b, sep_x, sep_y, sep_z,
               vel_a_x, vel_a_y, vel_a_z, vel_b_x, vel_b_y, vel_b_z,
        output ready
    );
endinterface

interface ecv_res_if;
    logic              valid;
    logic              ready;
    logic signed [31:0] new_a_x;
    logic signed [31:0] new_a_y;
    logic signed [31:0] new_a_z;
    logic signed [31:0] new_b_x;
    logic signed [31:0] new_b_y;
    logic signed [31:0] new_b_z;
    logic              degenerate;

    modport source (
        output valid, new_a_x, new_a_y, new_a_z, new_b_x, new_b_y, new_b_z, degenerate,
        input  ready
    );
    modport sink (
        input  valid, new_a_x, new_a_y, new_a_z, new_b_x, new_b_y, new_b_z, degenerate,
        output ready
    );
endinterface

[hw/rtl/ecv_div.sv]
// ---------------------------------------------------------------------------
// Elastic collision velocity - pipelined divider
// Restoring division, one quotient bit per stage, six lanes sharing a divisor.
// ---------------------------------------------------------------------------
module ecv_div (
    input  logic                                    clk,
    input  logic [ecv_pkg::QW-1:0]                  adv,
    input  ecv_pkg::dsr_t                           dsr,
    input  ecv_pkg::num_t [ecv_pkg::LANES-1:0]      num,
    output ecv_pkg::quot_t [ecv_pkg::LANES-1:0]     quot
);
    import ecv_pkg::*;

    dsr_t                         dsr_reg [QW];
    logic [LANES-1:0][DW-1:0]     rem_reg [QW];
    quot_t [LANES-1:0]            low_reg [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        dsr_t                     dsr_src;
        logic [LANES-1:0][DW-1:0] rem_src;
        quot_t [LANES-1:0]        low_src;
        logic [LANES-1:0][DW-1:0] rem_next;
        quot_t [LANES-1:0]        low_next;

        if (k == 0) begin : g_first
            // the quotient fits in QW bits, so the upper dividend is below the divisor
            always_comb
            begin
                dsr_src = dsr;
                for (int l = 0; l < LANES; l++)
                begin
                    rem_src[l] = DW'(num[l][NW-1:QW]);
                    low_src[l] = num[l][QW-1:0];
                end
            end
        end else begin : g_rest
            always_comb
            begin
                dsr_src = dsr_reg[k-1];
                rem_src = rem_reg[k-1];
                low_src = low_reg[k-1];
            end
        end

        always_comb
        begin
            logic [DW:0] trial;
            logic        ge;
            for (int l = 0; l < LANES; l++)
            begin
                trial       = {rem_src[l], low_src[l][QW-1]};
                ge          = (trial >= {1'b0, dsr_src});
                rem_next[l] = ge ? DW'(trial - {1'b0, dsr_src}) : DW'(trial);
                low_next[l] = {low_src[l][QW-2:0], ge};
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv[k])
            begin
                dsr_reg[k] <= dsr_src;
                rem_reg[k] <= rem_next;
                low_reg[k] <= low_next;
            end
        end
    end

    assign quot = low_reg[QW-1];

endmodule

[hw/rtl/elastic_collision_velocity_top.sv]
// ---------------------------------------------------------------------------
// Elastic collision velocity - top level
// Post-collision velocities of two bodies, perfectly elastic, exact rounding.
// ---------------------------------------------------------------------------
// Usage:
//   bodies      request channel: masses, separation B minus A, both velocities.
//   velocities  result channel: new velocities, saturated Q16.16, and a
//               degenerate flag (zero mass or zero separation: pass-through).
//   One result per request, in order, valid/ready handshake on both sides.
// Pipeline: products and sums, then the restoring divider (one quotient bit
//   per stage), then sign, add and saturate into the output register.
// Throughput: one request per cycle unless stalled, set by the fully pipelined divider.
// Reset clears every stage valid bit; the pipeline comes up empty and ready.
// When the receiver stalls the result holds in the output register and the
// stages behind it keep filling empty slots; ready drops only once all 45
// stages hold a request.
// ---------------------------------------------------------------------------
`include "elastic_collision_velocity_top_defines.svh"

module elastic_collision_velocity_top (
    input  logic      clk,
    input  logic      rst_n,
    ecv_req_if.sink   bodies,
    ecv_res_if.source velocities
);
    import ecv_pkg::*;

    localparam int LAST = NUM_STAGES - 1;

    // ---------------- stage control ----------------
    logic [NUM_STAGES-1:0] vld_reg;
    logic [NUM_STAGES-1:0] vld_next;
    logic [NUM_STAGES-1:0] adv;

    // a stage moves if any slot at or after it is empty, or the output drains
    always_comb
    begin
        for (int k = 0; k < NUM_STAGES; k++)
            adv[k] = velocities.ready
                     || ((~vld_reg & ({NUM_STAGES{1'b1}} << k)) != '0);
        vld_next = (adv & {vld_reg[NUM_STAGES-2:0], bodies.valid}) | (~adv & vld_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    assign bodies.ready = adv[0];

    // ---------------- stage 0: capture, differences, magnitudes ----------------
    logic signed [31:0] in_r  [AXES];
    logic signed [31:0] in_va [AXES];
    logic signed [31:0] in_vb [AXES];

    always_comb
    begin
        in_r[0]  = bodies.sep_x;   in_r[1]  = bodies.sep_y;   in_r[2]  = bodies.sep_z;
        in_va[0] = bodies.vel_a_x; in_va[1] = bodies.vel_a_y; in_va[2] = bodies.vel_a_z;
        in_vb[0] = bodies.vel_b_x; in_vb[1] = bodies.vel_b_y; in_vb[2] = bodies.vel_b_z;
    end

    logic signed [32:0] s0_dv_reg   [AXES];
    logic signed [31:0] s0_r_reg    [AXES];
    logic [31:0]        s0_rmag_reg [AXES];
    logic [32:0]        s0_m_reg;
    logic [32:0]        s0_fa_reg;
    logic [32:0]        s0_fb_reg;
    side_t              s0_side_reg;

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            for (int i = 0; i < AXES; i++)
            begin
                s0_dv_reg[i]        <= 33'(in_vb[i]) - 33'(in_va[i]);
                s0_r_reg[i]         <= in_r[i];
                s0_rmag_reg[i]      <= in_r[i][31] ? (~in_r[i] + 32'd1) : in_r[i];
                s0_side_reg.va[i]   <= in_va[i];
                s0_side_reg.vb[i]   <= in_vb[i];
                s0_side_reg.rneg[i] <= in_r[i][31];
            end
            s0_side_reg.pneg <= 1'b0;
            s0_side_reg.deg  <= (bodies.mass_a == '0) || (bodies.mass_b == '0)
                                || ((bodies.sep_x == '0) && (bodies.sep_y == '0)
                                    && (bodies.sep_z == '0));
            s0_m_reg  <= 33'(bodies.mass_a) + 33'(bodies.mass_b);
            s0_fa_reg <= {bodies.mass_b, 1'b0};
            s0_fb_reg <= {bodies.mass_a, 1'b0};
        end
    end

    // ---------------- stage 1: products ----------------
    logic [63:0]        s1_rsq_reg  [AXES];
    logic signed [64:0] s1_prod_reg [AXES];
    logic [64:0]        s1_u_reg    [LANES];
    logic [32:0]        s1_m_reg;
    side_t              s1_side_reg;

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            for (int i = 0; i < AXES; i++)
            begin
                s1_rsq_reg[i]    <= s0_rmag_reg[i] * s0_rmag_reg[i];
                s1_prod_reg[i]   <= s0_dv_reg[i] * s0_r_reg[i];
                s1_u_reg[i]      <= s0_fa_reg * s0_rmag_reg[i];
                s1_u_reg[i+AXES] <= s0_fb_reg * s0_rmag_reg[i];
            end
            s1_m_reg    <= s0_m_reg;
            s1_side_reg <= s0_side_reg;
        end
    end

    // ---------------- stage 2: |r|^2 and dv.r ----------------
    logic [63:0]        s2_s_reg;
    logic signed [66:0] s2_p_reg;
    logic [64:0]        s2_u_reg [LANES];
    logic [32:0]        s2_m_reg;
    side_t              s2_side_reg;

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            s2_s_reg    <= s1_rsq_reg[0] + s1_rsq_reg[1] + s1_rsq_reg[2];
            s2_p_reg    <= 67'(s1_prod_reg[0]) + 67'(s1_prod_reg[1]) + 67'(s1_prod_reg[2]);
            s2_u_reg    <= s1_u_reg;
            s2_m_reg    <= s1_m_reg;
            s2_side_reg <= s1_side_reg;
        end
    end

    // ---------------- stage 3: |P|, denominator partials ----------------
    logic [64:0] s3_pmag_reg;
    logic [65:0] s3_dl_reg;
    logic [63:0] s3_dh_reg;
    logic [64:0] s3_u_reg [LANES];
    side_t       s3_side_reg;

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            s3_pmag_reg <= s2_p_reg[66] ? 65'(-s2_p_reg) : 65'(s2_p_reg);
            s3_dl_reg   <= s2_m_reg * s2_s_reg[32:0];
            s3_dh_reg   <= s2_m_reg * s2_s_reg[63:33];
            s3_u_reg    <= s2_u_reg;
            s3_side_reg <= {s2_side_reg.va, s2_side_reg.vb, s2_side_reg.rneg,
                            s2_p_reg[66], s2_side_reg.deg};
        end
    end

    // ---------------- stage 4: denominator, numerator partials ----------------
    logic [DENW-1:0] s4_den_reg;
    logic [65:0]     s4_ll_reg [LANES];
    logic [64:0]     s4_lh_reg [LANES];
    logic [64:0]     s4_hl_reg [LANES];
    logic [63:0]     s4_hh_reg [LANES];
    side_t           s4_side_reg;

    always_ff @(posedge clk)
    begin
        if (adv[4])
        begin
            s4_den_reg <= DENW'(s3_dl_reg) + {s3_dh_reg, 33'b0};
            for (int l = 0; l < LANES; l++)
            begin
                s4_ll_reg[l] <= s3_pmag_reg[32:0]  * s3_u_reg[l][32:0];
                s4_lh_reg[l] <= s3_pmag_reg[32:0]  * s3_u_reg[l][64:33];
                s4_hl_reg[l] <= s3_pmag_reg[64:33] * s3_u_reg[l][32:0];
                s4_hh_reg[l] <= s3_pmag_reg[64:33] * s3_u_reg[l][64:33];
            end
            s4_side_reg <= s3_side_reg;
        end
    end

    // ---------------- stage 5: cross terms ----------------
    logic [DENW-1:0] s5_den_reg;
    logic [65:0]     s5_mid_reg [LANES];
    logic [129:0]    s5_cat_reg [LANES];
    side_t           s5_side_reg;

    always_ff @(posedge clk)
    begin
        if (adv[5])
        begin
            for (int l = 0; l < LANES; l++)
            begin
                s5_mid_reg[l] <= 66'(s4_lh_reg[l]) + 66'(s4_hl_reg[l]);
                s5_cat_reg[l] <= {s4_hh_reg[l], s4_ll_reg[l]};
            end
            s5_den_reg  <= s4_den_reg;
            s5_side_reg <= s4_side_reg;
        end
    end

    // ---------------- stage 6: full numerator 2*m*|P|*|r_i| ----------------
    logic [DENW-1:0] s6_den_reg;
    logic [129:0]    s6_na_reg [LANES];
    side_t           s6_side_reg;

    always_ff @(posedge clk)
    begin
        if (adv[6])
        begin
            for (int l = 0; l < LANES; l++)
                s6_na_reg[l] <= s5_cat_reg[l] + 130'({s5_mid_reg[l], 33'b0});
            s6_den_reg  <= s5_den_reg;
            s6_side_reg <= s5_side_reg;
        end
    end

    // ---------------- stage 7: round-to-nearest operands ----------------
    // round(n/d) = floor((2n + d) / 2d)
    num_t [LANES-1:0] s7_num_reg;
    dsr_t             s7_dsr_reg;
    side_t            s7_side_reg;

    always_ff @(posedge clk)
    begin
        if (adv[7])
        begin
            for (int l = 0; l < LANES; l++)
                s7_num_reg[l] <= {1'b0, s6_na_reg[l], 1'b0} + NW'(s6_den_reg);
            s7_dsr_reg  <= {s6_den_reg, 1'b0};
            s7_side_reg <= s6_side_reg;
        end
    end

    // ---------------- stages 8..43: divider ----------------
    quot_t [LANES-1:0] quot;
    side_t             div_side_reg [QW];

    ecv_div u_div (
        .clk  (clk),
        .adv  (adv[PRE_STAGES +: QW]),
        .dsr  (s7_dsr_reg),
        .num  (s7_num_reg),
        .quot (quot)
    );

    for (genvar k = 0; k < QW; k++) begin : g_side
        if (k == 0) begin : g_first
            always_ff @(posedge clk)
            begin
                if (adv[PRE_STAGES])
                    div_side_reg[0] <= s7_side_reg;
            end
        end else begin : g_rest
            always_ff @(posedge clk)
            begin
                if (adv[PRE_STAGES+k])
                    div_side_reg[k] <= div_side_reg[k-1];
            end
        end
    end

    // ---------------- final stage: sign, add, saturate ----------------
    side_t              fin_side;
    logic [31:0]        res_next [LANES];
    logic [31:0]        res_reg  [LANES];
    logic               deg_reg;

    assign fin_side = div_side_reg[QW-1];

    function automatic logic [31:0] sat32(input logic signed [37:0] v);
        logic [31:0] r;
        if (v[37:31] == '0 || v[37:31] == '1)
            r = v[31:0];
        else if (v[37])
            r = 32'h8000_0000;
        else
            r = 32'h7fff_ffff;
        return r;
    endfunction

    always_comb
    begin
        logic               negt;
        logic signed [37:0] da;
        logic signed [37:0] db;
        for (int i = 0; i < AXES; i++)
        begin
            negt = fin_side.pneg ^ fin_side.rneg[i];
            da   = negt ? -$signed({2'b0, quot[i]})      : $signed({2'b0, quot[i]});
            db   = negt ? -$signed({2'b0, quot[i+AXES]}) : $signed({2'b0, quot[i+AXES]});
            if (fin_side.deg)
            begin
                res_next[i]      = fin_side.va[i];
                res_next[i+AXES] = fin_side.vb[i];
            end
            else
            begin
                res_next[i]      = sat32(38'($signed(fin_side.va[i])) + da);
                res_next[i+AXES] = sat32(38'($signed(fin_side.vb[i])) - db);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[LAST])
        begin
            res_reg <= res_next;
            deg_reg <= fin_side.deg;
        end
    end

    assign velocities.valid      = vld_reg[LAST];
    assign velocities.new_a_x    = res_reg[0];
    assign velocities.new_a_y    = res_reg[1];
    assign velocities.new_a_z    = res_reg[2];
    assign velocities.new_b_x    = res_reg[3];
    assign velocities.new_b_y    = res_reg[4];
    assign velocities.new_b_z    = res_reg[5];
    assign velocities.degenerate = deg_reg;

    // ---------------- checks ----------------
    logic q_msb_any;

    always_comb
    begin
        q_msb_any = 1'b0;
        for (int l = 0; l < LANES; l++)
            q_msb_any = q_msb_any | quot[l][QW-1];
    end

    `ECV_ASSERT_IMPLY(a_ready_when_out_empty, !velocities.valid, bodies.ready)
    `ECV_ASSERT_IMPLY(a_ready_when_out_drains, velocities.ready, bodies.ready)
    `ECV_ASSERT_IMPLY(a_quot_in_range, vld_reg[LAST-1] && !fin_side.deg, !q_msb_any)
    `ECV_ASSERT_NEXT(a_accept_fills_entry, bodies.valid && bodies.ready, vld_reg[0])

endmodule
